// ===== rtl/srp_pkg.sv =====
// Shared types, constants and a helper function for the stepper ramp positioner.
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

    // Default width of the position and destination counters
    localparam int POSITION_BITS_DEFAULT = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PERIOD       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECEL_SPAN       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOME_POSITION    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOME_WINDOW_LOW  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOME_WINDOW_HIGH = 3'd4;

    // Input word modes
    localparam logic [1:0] MODE_TICK      = 2'd0;
    localparam logic [1:0] MODE_SET_DEST  = 2'd1;
    localparam logic [1:0] MODE_HOME      = 2'd2;
    localparam logic [1:0] MODE_CLEAR_HOME = 2'd3;

    // Configuration reset values
    localparam logic [7:0]         MIN_PERIOD_RESET       = 8'd40;
    localparam logic [6:0]         DECEL_SPAN_RESET       = 7'd30;
    localparam logic signed [15:0] HOME_POSITION_RESET    = 16'sd100;
    localparam logic signed [15:0] HOME_WINDOW_LOW_RESET  = 16'sd80;
    localparam logic signed [15:0] HOME_WINDOW_HIGH_RESET = 16'sd120;

    // Period limits; reset period is the saturated sum of the reset config
    localparam logic [7:0] PERIOD_MAX = 8'd255;
    localparam int PERIOD_RESET_SUM = int'(MIN_PERIOD_RESET) + int'(DECEL_SPAN_RESET);
    localparam logic [7:0] PERIOD_RESET =
        8'((PERIOD_RESET_SUM > 255) ? 255 : PERIOD_RESET_SUM);

    // Configuration register set
    typedef struct packed {
        logic [7:0]         min_period;
        logic [6:0]         decel_span;
        logic signed [15:0] home_position;
        logic signed [15:0] home_window_low;
        logic signed [15:0] home_window_high;
    } srp_cfg_t;

    // One result word
    typedef struct packed {
        logic               step_pulse;
        logic               step_direction;
        logic signed [15:0] position;
        logic [7:0]         period;
        logic               at_destination;
        logic               home_seen;
    } srp_result_t;

    // Reload period: min_period + decel_span, saturated at the period maximum
    function automatic logic [7:0] reload_period(input logic [7:0] min_p,
                                                 input logic [6:0] slope);
        logic [8:0] sum;
        sum = {1'b0, min_p} + {2'b00, slope};
        return sum[8] ? PERIOD_MAX : sum[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/srp_cfg.sv =====
// Configuration register file of the stepper ramp positioner.
`timescale 1ns / 1ps
`default_nettype none

module srp_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [srp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [srp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output srp_pkg::srp_cfg_t                        cfg
);
    import srp_pkg::*;

    srp_cfg_t cfg_reg;

    // Always take a write word
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Hold registers, update the addressed one on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_period       <= MIN_PERIOD_RESET;
            cfg_reg.decel_span       <= DECEL_SPAN_RESET;
            cfg_reg.home_position    <= HOME_POSITION_RESET;
            cfg_reg.home_window_low  <= HOME_WINDOW_LOW_RESET;
            cfg_reg.home_window_high <= HOME_WINDOW_HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_PERIOD:       cfg_reg.min_period       <= cfg_data[7:0];
                CFG_DECEL_SPAN:       cfg_reg.decel_span       <= cfg_data[6:0];
                CFG_HOME_POSITION:    cfg_reg.home_position    <= $signed(cfg_data);
                CFG_HOME_WINDOW_LOW:  cfg_reg.home_window_low  <= $signed(cfg_data);
                CFG_HOME_WINDOW_HIGH: cfg_reg.home_window_high <= $signed(cfg_data);
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srp_core.sv =====
// Positioner state and single-pass next-state logic for one input word.
`timescale 1ns / 1ps
`default_nettype none

module srp_core #(
    parameter int POSITION_BITS = srp_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic [1:0]          mode,
    input  wire logic signed [15:0]  new_destination,
    input  wire srp_pkg::srp_cfg_t   cfg,
    output srp_pkg::srp_result_t     result
);
    import srp_pkg::*;

    localparam int P = POSITION_BITS;

    logic signed [P-1:0] pos_reg, pos_next;
    logic signed [P-1:0] dest_reg, dest_next;
    logic [7:0]          period_reg, period_next;
    logic [7:0]          tick_reg, tick_next;
    logic                home_reg, home_next;

    logic signed [P-1:0] dest_in, win_low, win_high, home_pos;
    logic [P:0]          dist_up, dist_dn, slope_ext;
    logic                fire, below, above, near_up, near_dn, near;
    logic [7:0]          period_ramp;
    logic                pulse, dir;

    // Fit 16-bit values to the position width
    assign dest_in  = P'(new_destination);
    assign win_low  = P'(cfg.home_window_low);
    assign win_high = P'(cfg.home_window_high);
    assign home_pos = P'(cfg.home_position);

    // Distance to destination in either direction, one bit wider than position
    assign dist_up   = (P+1)'(dest_reg) - (P+1)'(pos_reg);
    assign dist_dn   = (P+1)'(pos_reg) - (P+1)'(dest_reg);
    assign slope_ext = (P+1)'(cfg.decel_span);
    assign near_up   = dist_up < slope_ext;
    assign near_dn   = dist_dn < slope_ext;

    assign below = pos_reg < dest_reg;
    assign above = pos_reg > dest_reg;
    assign near  = below ? near_up : near_dn;
    assign fire  = (mode == MODE_TICK) && (tick_reg >= period_reg);

    // Ramp: slow down near the destination, speed up toward the minimum
    always_comb
    begin
        period_ramp = period_reg;
        if (near)
        begin
            if (period_reg != PERIOD_MAX)
                period_ramp = period_reg + 8'd1;
        end
        else if (period_reg > cfg.min_period)
        begin
            period_ramp = period_reg - 8'd1;
        end
    end

    // Next state for the current word
    always_comb
    begin
        pos_next    = pos_reg;
        dest_next   = dest_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        home_next   = home_reg;
        pulse       = 1'b0;
        dir         = 1'b0;
        unique case (mode)
            MODE_TICK:
            begin
                if (fire)
                begin
                    tick_next = '0;
                    if (below)
                    begin
                        period_next = period_ramp;
                        pos_next    = pos_reg + P'(1);
                        pulse       = 1'b1;
                    end
                    else if (above)
                    begin
                        period_next = period_ramp;
                        pos_next    = pos_reg - P'(1);
                        pulse       = 1'b1;
                        dir         = 1'b1;
                    end
                    if (pos_next == dest_reg)
                        period_next = reload_period(cfg.min_period, cfg.decel_span);
                end
                else
                begin
                    tick_next = tick_reg + 8'd1;
                end
            end
            MODE_SET_DEST:
            begin
                dest_next = dest_in;
            end
            MODE_HOME:
            begin
                home_next = 1'b1;
                if ((pos_reg < win_low) || (pos_reg > win_high))
                    pos_next = home_pos;
            end
            MODE_CLEAR_HOME:
            begin
                home_next = 1'b0;
            end
            default:
            begin
                home_next = home_reg;
            end
        endcase
    end

    // Result word built from the next state
    always_comb
    begin
        result.step_pulse     = pulse;
        result.step_direction = dir;
        result.position       = 16'(pos_next);
        result.period         = period_next;
        result.at_destination = (pos_next == dest_next);
        result.home_seen      = home_next;
    end

    // Advance state once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            dest_reg   <= '0;
            period_reg <= PERIOD_RESET;
            tick_reg   <= '0;
            home_reg   <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            dest_reg   <= dest_next;
            period_reg <= period_next;
            tick_reg   <= tick_next;
            home_reg   <= home_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stepper_ramp_positioner.sv =====
// Top level of the stepper ramp positioner: handshake stages around the core.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    mode, new_destination
//   out      out_valid / out_ready  step_pulse, step_direction, position, period,
//                                   at_destination, home_seen
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per clock sustained while out_ready is high; a taken word moves from the input
// register to the result register when that is free or being drained, and leaves from there.
// The core state updates in the same cycle a word moves into the result register.
// A stalled output holds its word; the input register still takes one more word.
// Reset restores the configuration defaults and clears position, destination,
// tick counter and home flag; the period starts at min_period + decel_span.
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_positioner #(
    parameter int POSITION_BITS = srp_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          mode,
    input  wire logic signed [15:0]                  new_destination,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     step_pulse,
    output logic                                     step_direction,
    output logic signed [15:0]                       position,
    output logic [7:0]                               period,
    output logic                                     at_destination,
    output logic                                     home_seen,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [srp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [srp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import srp_pkg::*;

    srp_cfg_t            cfg;
    srp_result_t         result, result_reg;
    logic                in_full_reg, in_full_next;
    logic                out_full_reg, out_full_next;
    logic [1:0]          mode_reg;
    logic signed [15:0]  dest_word_reg;
    logic                advance, in_take;

    srp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .mode            (mode_reg),
        .new_destination (dest_word_reg),
        .cfg             (cfg),
        .result          (result)
    );

    // Move a word forward when the result register is free or being drained
    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_full_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_full_reg);
        out_full_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_full_reg);
    end

    // Hold stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    // Capture input word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg      <= mode;
            dest_word_reg <= new_destination;
        end
    end

    // Capture result word
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result;
    end

    assign out_valid      = out_full_reg;
    assign step_pulse     = result_reg.step_pulse;
    assign step_direction = result_reg.step_direction;
    assign position       = result_reg.position;
    assign period         = result_reg.period;
    assign at_destination = result_reg.at_destination;
    assign home_seen      = result_reg.home_seen;

endmodule

`default_nettype wire
